// File: rtl/sst_pkg.sv
// Shared types, constants and helpers for the sorted set table.
package sst_pkg;

  localparam int DEPTH = 64;
  localparam int VAL_W = 64;
  localparam int KEY_W = VAL_W + 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int POS_W = 7;

  typedef logic [KEY_W-1:0] key_t;
  typedef logic [CNT_W-1:0] cnt_t;

  typedef enum logic [1:0] {
    OP_QUERY  = 2'd0,
    OP_INSERT = 2'd1,
    OP_DELETE = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    STAT_DONE     = 2'd0,
    STAT_NOCHANGE = 2'd1,
    STAT_FULL     = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_LOAD,
    CELL_UP,
    CELL_DOWN
  } cell_op_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_CMP,
    S_UPD
  } sst_state_t;

  typedef struct packed {
    logic load;
    logic compare;
    logic update;
  } sst_cmd_t;

  // Map to one unsigned order: negative class below, signed order inside it.
  function automatic key_t map_key(input logic neg, input logic [VAL_W-1:0] val);
    return {~neg, val ^ {neg, {(VAL_W-1){1'b0}}}};
  endfunction

  function automatic logic [POS_W-1:0] to_pos(input logic [CNT_W:0] v);
    logic [CNT_W+POS_W:0] w;
    w = {{POS_W{1'b0}}, v};
    return w[POS_W-1:0];
  endfunction

endpackage

// File: rtl/sst_cell.sv
// One table slot: stored key, compare against the search key, shift mux.
module sst_cell import sst_pkg::*; (
  input  logic     clk,
  input  cell_op_t op,
  input  key_t     key,
  input  key_t     prev_data,
  input  key_t     next_data,
  output key_t     data,
  output logic     lt,
  output logic     eq
);

  key_t entry_r;
  key_t entry_nxt;

  always_comb begin
    unique case (op)
      CELL_LOAD: entry_nxt = key;
      CELL_UP:   entry_nxt = prev_data;
      CELL_DOWN: entry_nxt = next_data;
      default:   entry_nxt = entry_r;
    endcase
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

  assign data = entry_r;
  assign lt   = entry_r < key;
  assign eq   = entry_r == key;

endmodule

// File: rtl/sst_datapath.sv
// Datapath: key register, cell row, compare capture, locate and update logic.
module sst_datapath import sst_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  sst_cmd_t         cmd,
  input  logic [1:0]       in_op,
  input  logic             in_key_negative,
  input  logic [VAL_W-1:0] in_key_value,
  output logic             out_valid,
  output logic             out_found,
  output logic [POS_W-1:0] out_position,
  output logic [POS_W-1:0] out_insert_position,
  output logic [1:0]       out_status,
  output logic [POS_W-1:0] out_count_after
);

  key_t             key_r;
  logic [1:0]       op_r;
  logic [DEPTH-1:0] lt_r;
  logic [DEPTH-1:0] eq_r;
  cnt_t             count_r;
  cnt_t             count_nxt;

  logic             out_valid_r;
  logic             out_found_r;
  logic [POS_W-1:0] out_position_r;
  logic [POS_W-1:0] out_insert_position_r;
  logic [1:0]       out_status_r;
  logic [POS_W-1:0] out_count_after_r;

  key_t             cell_data [DEPTH];
  cell_op_t         cell_op   [DEPTH];
  logic [DEPTH-1:0] cell_lt;
  logic [DEPTH-1:0] cell_eq;

  logic [DEPTH-1:0] valid;
  logic [DEPTH-1:0] upto;
  logic [DEPTH-1:0] ltv;
  logic [DEPTH-1:0] eqv;
  logic [DEPTH-1:0] at_idx;
  logic [DEPTH-1:0] tail;
  logic [DEPTH-1:0] down_ok;

  cnt_t             idx;
  logic [CNT_W:0]   idx_inc;
  logic             found;
  logic             full;
  logic             do_ins;
  logic             do_del;
  status_t          status;

  for (genvar g = 0; g < DEPTH; g++) begin : g_row
    assign valid[g] = count_r > CNT_W'(g);
    assign upto[g]  = count_r >= CNT_W'(g);

    if (g == 0) begin : g_first
      assign at_idx[g] = ~ltv[g];
    end else begin : g_rest
      assign at_idx[g] = ~ltv[g] & ltv[g-1];
    end

    if (g == DEPTH - 1) begin : g_last
      assign tail[g]    = ltv[g];
      assign down_ok[g] = 1'b0;
    end else begin : g_mid
      assign tail[g]    = ltv[g] & ~ltv[g+1];
      assign down_ok[g] = valid[g+1];
    end

    key_t prev_d;
    key_t next_d;
    if (g == 0) begin : g_p0
      assign prev_d = key_r;
    end else begin : g_pn
      assign prev_d = cell_data[g-1];
    end
    if (g == DEPTH - 1) begin : g_nl
      assign next_d = cell_data[g];
    end else begin : g_nn
      assign next_d = cell_data[g+1];
    end

    sst_cell u_cell (
      .clk       (clk),
      .op        (cell_op[g]),
      .key       (key_r),
      .prev_data (prev_d),
      .next_data (next_d),
      .data      (cell_data[g]),
      .lt        (cell_lt[g]),
      .eq        (cell_eq[g])
    );
  end

  // Entries below the key form a thermometer from slot 0; its top marks idx.
  always_comb begin
    ltv   = lt_r & valid;
    eqv   = eq_r & valid;
    found = |eqv;
    full  = count_r == CNT_W'(DEPTH);
    idx   = '0;
    for (int g = 0; g < DEPTH; g++) begin
      if (tail[g]) begin
        idx = idx | CNT_W'(g + 1);
      end
    end
    idx_inc = {1'b0, idx} + {{CNT_W{1'b0}}, 1'b1};
    do_ins  = cmd.update && (op_r == OP_INSERT) && !found && !full;
    do_del  = cmd.update && (op_r == OP_DELETE) && found;
  end

  always_comb begin
    for (int g = 0; g < DEPTH; g++) begin
      cell_op[g] = CELL_HOLD;
      if (do_ins) begin
        if (at_idx[g]) begin
          cell_op[g] = CELL_LOAD;
        end else if (!ltv[g] && upto[g]) begin
          cell_op[g] = CELL_UP;
        end
      end else if (do_del) begin
        if (!ltv[g] && down_ok[g]) begin
          cell_op[g] = CELL_DOWN;
        end
      end
    end
  end

  always_comb begin
    unique case (op_r)
      OP_INSERT: status = found ? STAT_NOCHANGE : (full ? STAT_FULL : STAT_DONE);
      OP_DELETE: status = found ? STAT_DONE : STAT_NOCHANGE;
      default:   status = STAT_DONE;
    endcase
  end

  always_comb begin
    if (do_ins) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (do_del) begin
      count_nxt = count_r - CNT_W'(1);
    end else begin
      count_nxt = count_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      key_r <= map_key(in_key_negative, in_key_value);
      op_r  <= in_op;
    end
    if (cmd.compare) begin
      lt_r <= cell_lt;
      eq_r <= cell_eq;
    end
    if (cmd.update) begin
      out_found_r           <= found;
      out_position_r        <= found ? to_pos(idx_inc) : '0;
      out_insert_position_r <= found ? '0 : to_pos(idx_inc);
      out_status_r          <= status;
      out_count_after_r     <= to_pos({1'b0, count_nxt});
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      out_valid_r <= cmd.update;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_found           = out_found_r;
  assign out_position        = out_position_r;
  assign out_insert_position = out_insert_position_r;
  assign out_status          = out_status_r;
  assign out_count_after     = out_count_after_r;

endmodule

// File: rtl/sst_ctrl.sv
// Controller: sequences accept, compare and update steps of each transaction.
module sst_ctrl import sst_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  output logic     busy,
  output sst_cmd_t cmd
);

  sst_state_t state_r;
  sst_state_t state_nxt;
  logic       accept;

  assign accept = start && !busy;

  always_comb begin
    unique case (state_r)
      S_IDLE:  state_nxt = accept ? S_CMP : S_IDLE;
      S_CMP:   state_nxt = S_UPD;
      S_UPD:   state_nxt = accept ? S_CMP : S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // A new key may load while the previous update lands in the cells.
  always_comb begin
    busy        = 1'b0;
    cmd.load    = 1'b0;
    cmd.compare = 1'b0;
    cmd.update  = 1'b0;
    unique case (state_r)
      S_CMP: begin
        busy        = 1'b1;
        cmd.compare = 1'b1;
      end
      S_UPD: begin
        cmd.update = 1'b1;
        cmd.load   = start;
      end
      default: begin
        cmd.load = start;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// File: rtl/sorted_set_table_core.sv
// Top level of the sorted set table: controller plus datapath.
// The result strobe is registered at the end of the update step, after compare.
// A new transaction may be accepted in the update step; busy is high in the
// compare step after an accept, while all cells compare; the cell shift follows.
// Reset clears the entry count and output strobe; cell contents are left as
// they are and only slots below the count are ever used. No output stall.
module sorted_set_table_core import sst_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  output logic             busy,
  input  logic [1:0]       in_op,
  input  logic             in_key_negative,
  input  logic [VAL_W-1:0] in_key_value,
  output logic             out_valid,
  output logic             out_found,
  output logic [POS_W-1:0] out_position,
  output logic [POS_W-1:0] out_insert_position,
  output logic [1:0]       out_status,
  output logic [POS_W-1:0] out_count_after
);

  sst_cmd_t cmd;

  sst_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .cmd   (cmd)
  );

  sst_datapath u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .in_op               (in_op),
    .in_key_negative     (in_key_negative),
    .in_key_value        (in_key_value),
    .out_valid           (out_valid),
    .out_found           (out_found),
    .out_position        (out_position),
    .out_insert_position (out_insert_position),
    .out_status          (out_status),
    .out_count_after     (out_count_after)
  );

  a_accept_then_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("busy not raised after accept");

  a_busy_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
    busy |=> (!busy && cmd.update))
    else $error("compare step not followed by update");

  a_found_positions: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_found == (out_position != '0)) &&
                   (out_found == (out_insert_position == '0))))
    else $error("position fields disagree with found");

  a_full_refusal: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status == STAT_FULL)) |->
      (!out_found && (out_count_after == to_pos((CNT_W+1)'(DEPTH)))))
    else $error("full refusal with wrong count");

endmodule
